### src/exl_pkg.sv
// exl_pkg: shared types, character codes and token categories of the expression lexer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package exl_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [4:0] CAT_ADD  = 5'd0;
	localparam logic [4:0] CAT_SUB  = 5'd1;
	localparam logic [4:0] CAT_MUL  = 5'd2;
	localparam logic [4:0] CAT_DIV  = 5'd3;
	localparam logic [4:0] CAT_LPAR = 5'd4;
	localparam logic [4:0] CAT_RPAR = 5'd5;
	localparam logic [4:0] CAT_EXP  = 5'd6;
	localparam logic [4:0] CAT_LT   = 5'd7;
	localparam logic [4:0] CAT_LE   = 5'd8;
	localparam logic [4:0] CAT_GT   = 5'd9;
	localparam logic [4:0] CAT_GE   = 5'd10;
	localparam logic [4:0] CAT_EQ   = 5'd11;
	localparam logic [4:0] CAT_NE   = 5'd12;
	localparam logic [4:0] CAT_SEMI = 5'd13;
	localparam logic [4:0] CAT_INT  = 5'd14;
	localparam logic [4:0] CAT_ERR  = 5'd15;
	localparam logic [4:0] CAT_END  = 5'd16;

	typedef enum logic [2:0] {
		PK_NONE,
		PK_LT,
		PK_GT,
		PK_EQ,
		PK_BANG,
		PK_INT
	} pend_t;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ERROR,
		MODE_IGNORE
	} mode_t;

	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  len;
	} lexbuf_t;

	typedef struct packed {
		logic [4:0]  cat;
		logic [63:0] text;
		logic [3:0]  len;
	} res_t;

	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} bundle_t;

	function automatic logic is_space(logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic is_single(logic [7:0] c);
		return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR,
			CH_CARET, CH_SEMI};
	endfunction

	function automatic logic [4:0] single_cat(logic [7:0] c);
		logic [4:0] r;
		case (c)
			CH_PLUS:  r = CAT_ADD;
			CH_MINUS: r = CAT_SUB;
			CH_STAR:  r = CAT_MUL;
			CH_SLASH: r = CAT_DIV;
			CH_LPAR:  r = CAT_LPAR;
			CH_RPAR:  r = CAT_RPAR;
			CH_CARET: r = CAT_EXP;
			default:  r = CAT_SEMI;
		endcase
		return r;
	endfunction

	function automatic res_t mk_res(logic [4:0] cat, logic [63:0] text, logic [3:0] len);
		res_t r;
		r.cat  = cat;
		r.text = text;
		r.len  = len;
		return r;
	endfunction

	function automatic lexbuf_t buf_add(lexbuf_t b, logic [7:0] c, logic [3:0] maxv);
		lexbuf_t r;
		r = b;
		if (b.len < maxv && b.len < 4'd8) begin
			for (int i = 0; i < 8; i++) begin
				if (b.len[2:0] == 3'(i))
					r.text[8*i +: 8] = c;
			end
			r.len = b.len + 4'd1;
		end
		return r;
	endfunction

endpackage

### src/exl_front.sv
// exl_front: lexer state and byte classifier; turns each accepted byte into a bundle
// of zero, one or two results. Depends on exl_pkg.
`timescale 1ns / 1ps
module exl_front #(
	parameter int MAX_LEXEME = 8,
	parameter int MAX_ERROR  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        char_in,
	output logic              enq,
	output exl_pkg::bundle_t  bundle
);
	import exl_pkg::*;

	localparam logic [3:0] MaxLex = 4'(MAX_LEXEME);
	localparam logic [3:0] MaxErr = 4'(MAX_ERROR);

	pend_t   pend_q, pend_d;
	mode_t   mode_q, mode_d;
	lexbuf_t pbuf_q, pbuf_d;
	lexbuf_t ebuf_q, ebuf_d;

	res_t       res [2];
	logic [1:0] cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PK_NONE;
			mode_q <= MODE_NORMAL;
			pbuf_q <= '0;
			ebuf_q <= '0;
		end else if (take) begin
			pend_q <= pend_d;
			mode_q <= mode_d;
			pbuf_q <= pbuf_d;
			ebuf_q <= ebuf_d;
		end
	end

	always_comb begin
		logic       perr;
		logic       pnorm;
		logic       done;
		logic [7:0] held;
		logic [7:0] c;
		c      = char_in;
		pend_d = pend_q;
		mode_d = mode_q;
		pbuf_d = pbuf_q;
		ebuf_d = ebuf_q;
		res[0] = '0;
		res[1] = '0;
		cnt    = 2'd0;
		perr   = 1'b0;
		pnorm  = 1'b0;
		done   = 1'b0;
		held   = CH_EQ;
		case (mode_q)
			MODE_IGNORE: begin
				if (c == CH_NUL) begin
					res[0] = mk_res(CAT_END, '0, 4'd0);
					cnt    = 2'd1;
					mode_d = MODE_NORMAL;
				end
			end
			MODE_ERROR: begin
				pend_d = PK_NONE;
				if (pend_q == PK_EQ || pend_q == PK_BANG) begin
					held = (pend_q == PK_EQ) ? CH_EQ : CH_BANG;
					if (c == CH_EQ) begin
						res[0] = mk_res(CAT_ERR, ebuf_q.text, ebuf_q.len);
						cnt    = 2'd1;
						ebuf_d = '0;
						mode_d = MODE_IGNORE;
					end else begin
						ebuf_d = buf_add(ebuf_q, held, MaxErr);
						perr   = 1'b1;
					end
				end else begin
					perr = 1'b1;
				end
			end
			default: begin
				pend_d = PK_NONE;
				case (pend_q)
					PK_INT: begin
						if (is_digit(c)) begin
							if (pbuf_q.len < MaxLex && pbuf_q.len < 4'd8) begin
								pbuf_d = buf_add(pbuf_q, c, MaxLex);
							end else begin
								res[0] = mk_res(CAT_INT, pbuf_q.text, pbuf_q.len);
								cnt    = 2'd1;
								pbuf_d = '{text: {56'd0, c}, len: 4'd1};
							end
							pend_d = PK_INT;
							done   = 1'b1;
						end else begin
							res[0] = mk_res(CAT_INT, pbuf_q.text, pbuf_q.len);
							cnt    = 2'd1;
							pbuf_d = '0;
						end
					end
					PK_LT, PK_GT: begin
						held = (pend_q == PK_LT) ? CH_LT : CH_GT;
						if (c == CH_EQ) begin
							res[0] = mk_res((pend_q == PK_LT) ? CAT_LE : CAT_GE,
								{48'd0, CH_EQ, held}, 4'd2);
							done = 1'b1;
						end else begin
							res[0] = mk_res((pend_q == PK_LT) ? CAT_LT : CAT_GT,
								{56'd0, held}, 4'd1);
						end
						cnt = 2'd1;
					end
					PK_EQ, PK_BANG: begin
						held = (pend_q == PK_EQ) ? CH_EQ : CH_BANG;
						if (c == CH_EQ) begin
							res[0] = mk_res((pend_q == PK_EQ) ? CAT_EQ : CAT_NE,
								{48'd0, CH_EQ, held}, 4'd2);
							cnt    = 2'd1;
						end else begin
							mode_d = MODE_ERROR;
							ebuf_d = buf_add('0, held, MaxErr);
							perr   = 1'b1;
						end
						done = 1'b1;
					end
					default: ;
				endcase
				pnorm = !done;
			end
		endcase

		if (pnorm) begin
			if (c == CH_NUL) begin
				res[cnt[0]] = mk_res(CAT_END, '0, 4'd0);
				cnt         = cnt + 2'd1;
			end else if (is_space(c)) begin
			end else if (is_single(c)) begin
				res[cnt[0]] = mk_res(single_cat(c), {56'd0, c}, 4'd1);
				cnt         = cnt + 2'd1;
			end else if (c == CH_LT) begin
				pend_d = PK_LT;
			end else if (c == CH_GT) begin
				pend_d = PK_GT;
			end else if (c == CH_EQ) begin
				pend_d = PK_EQ;
			end else if (c == CH_BANG) begin
				pend_d = PK_BANG;
			end else if (is_digit(c)) begin
				pend_d = PK_INT;
				pbuf_d = '{text: {56'd0, c}, len: 4'd1};
			end else begin
				mode_d = MODE_ERROR;
				pend_d = PK_NONE;
				ebuf_d = buf_add('0, c, MaxErr);
			end
		end

		if (perr) begin
			if (c == CH_NUL) begin
				res[cnt[0]] = mk_res(CAT_ERR, ebuf_d.text, ebuf_d.len);
				res[1]      = mk_res(CAT_END, '0, 4'd0);
				cnt         = 2'd2;
				ebuf_d      = '0;
				mode_d      = MODE_NORMAL;
			end else if (is_space(c)) begin
			end else if (c == CH_EQ || c == CH_BANG) begin
				pend_d = (c == CH_EQ) ? PK_EQ : PK_BANG;
			end else if (is_single(c) || c == CH_LT || c == CH_GT || is_digit(c)) begin
				res[cnt[0]] = mk_res(CAT_ERR, ebuf_d.text, ebuf_d.len);
				cnt         = cnt + 2'd1;
				ebuf_d      = '0;
				pend_d      = PK_NONE;
				mode_d      = MODE_IGNORE;
			end else begin
				ebuf_d = buf_add(ebuf_d, c, MaxErr);
			end
		end

		enq        = take && (cnt != 2'd0);
		bundle.two = (cnt == 2'd2);
		bundle.r0  = res[0];
		bundle.r1  = res[1];
	end

endmodule

### src/exl_queue.sv
// exl_queue: four-entry queue of result bundles between the lexer front and the output
// back end. Depends on exl_pkg.
`timescale 1ns / 1ps
module exl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enq,
	input  exl_pkg::bundle_t  enq_data,
	input  logic              deq,
	output exl_pkg::bundle_t  head,
	output logic              qempty,
	output logic              qfull
);
	import exl_pkg::*;

	bundle_t    mem_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] count_q;

	logic do_enq, do_deq;

	assign qempty = (count_q == 3'd0);
	assign qfull  = (count_q == 3'd4);
	assign do_enq = enq && !qfull;
	assign do_deq = deq && !qempty;
	assign head   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_enq)
			mem_q[wptr_q] <= enq_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 2'd0;
			rptr_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (do_enq)
				wptr_q <= wptr_q + 2'd1;
			if (do_deq)
				rptr_q <= rptr_q + 2'd1;
			case ({do_enq, do_deq})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/exl_back.sv
// exl_back: splits queued bundles into single results and holds the oldest in an output
// register until popped. Depends on exl_pkg.
`timescale 1ns / 1ps
module exl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  exl_pkg::bundle_t  head,
	input  logic              qempty,
	output logic              deq,
	input  logic              pop,
	output logic              empty,
	output logic [4:0]        category,
	output logic [63:0]       lexeme_text,
	output logic [3:0]        lexeme_length,
	output logic              last_of_run
);
	import exl_pkg::*;

	res_t out_q;
	logic last_q;
	logic valid_q;
	logic sel_q;
	logic load;
	logic first_of_two;

	assign load         = !valid_q || pop;
	assign first_of_two = !sel_q && head.two;
	assign deq          = load && !qempty && !first_of_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !qempty;
			if (!qempty)
				sel_q <= first_of_two;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qempty) begin
			out_q  <= sel_q ? head.r1 : head.r0;
			last_q <= !first_of_two;
		end
	end

	assign empty         = !valid_q;
	assign category      = out_q.cat;
	assign lexeme_text   = out_q.text;
	assign lexeme_length = out_q.len;
	assign last_of_run   = last_q;

endmodule

### src/expression_lexer.sv
// expression_lexer: top level of the streaming expression lexer.
// Instantiates exl_front, exl_queue and exl_back; depends on exl_pkg.
//
// Usage:
//   Input is a queue-style write side: drive char_in with push high; the byte is
//   taken on a rising edge with full low. One byte per cycle is taken while the
//   internal bundle queue has room. Byte 0 ends a line.
//   Results are a queue-style read side: while empty is low, the oldest token sits
//   on category, lexeme_text, lexeme_length and last_of_run; pulse pop to take it.
//   A byte yields zero, one or two results; last_of_run marks the final one.
//   A taken byte's results pass through the bundle queue into the output register.
//   Throughput: one byte per cycle in while the queue has room, one result per cycle
//   out while pop is held; a byte that yields two results takes the single output
//   register in exl_back once for each of them.
//   A stalled reader holds the current result; the four-entry bundle queue fills
//   and then full rises until pop frees an entry.
//   Reset (arst_n low) clears the lexer state to normal scanning with nothing
//   pending and empties the queue and output register.
`timescale 1ns / 1ps
module expression_lexer #(
	parameter int MAX_LEXEME = 8,
	parameter int MAX_ERROR  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_in,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  category,
	output logic [63:0] lexeme_text,
	output logic [3:0]  lexeme_length,
	output logic        last_of_run
);
	import exl_pkg::*;

	bundle_t fbundle;
	bundle_t head;
	logic    enq;
	logic    deq;
	logic    qempty;
	logic    qfull;
	logic    take;

	assign full = qfull;
	assign take = push && !qfull;

	exl_front #(
		.MAX_LEXEME(MAX_LEXEME),
		.MAX_ERROR (MAX_ERROR)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.char_in(char_in),
		.enq    (enq),
		.bundle (fbundle)
	);

	exl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_data(fbundle),
		.deq     (deq),
		.head    (head),
		.qempty  (qempty),
		.qfull   (qfull)
	);

	exl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qempty       (qempty),
		.deq          (deq),
		.pop          (pop),
		.empty        (empty),
		.category     (category),
		.lexeme_text  (lexeme_text),
		.lexeme_length(lexeme_length),
		.last_of_run  (last_of_run)
	);

endmodule

### src/exl_checker.sv
// exl_checker: port-level assertions for expression_lexer, attached by bind.
// Depends on exl_pkg and the top level's ports.
`timescale 1ns / 1ps
module exl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [4:0]  category,
	input logic [63:0] lexeme_text,
	input logic [3:0]  lexeme_length,
	input logic        last_of_run
);
	import exl_pkg::*;

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty}))
		else $error("handshake flags unknown");

	a_cat_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> category <= CAT_END)
		else $error("category out of range");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && category == CAT_END) |->
			(lexeme_length == 4'd0 && lexeme_text == 64'd0 && last_of_run))
		else $error("malformed end marker");

	a_token_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && category != CAT_END && category != CAT_ERR) |->
			(lexeme_length != 4'd0 && lexeme_length <= 4'd8))
		else $error("token length out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(category) && $stable(lexeme_text)
			&& $stable(lexeme_length) && $stable(last_of_run)))
		else $error("stalled request changed");

endmodule

bind expression_lexer exl_checker u_exl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.category     (category),
	.lexeme_text  (lexeme_text),
	.lexeme_length(lexeme_length),
	.last_of_run  (last_of_run)
);
